// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tpc_pkg.sv =====
// Package: widths, reset values, constants and register indexes of the commutator.
`timescale 1ns / 1ps

package tpc_pkg;

	// parameter defaults
	localparam int PHASE_BITS_DEF = 6;
	localparam int IIR_SHIFT_DEF  = 8;
	localparam int PWM_TOP_DEF    = 32;

	// field and state widths
	localparam int SPEED_W    = 8;
	localparam int LOW_W      = 6;
	localparam int MSD_W      = 8;
	localparam int THR_W      = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int ADV_W      = 7;
	localparam int COMP_W     = 7;
	localparam int WAIT_W     = 8;
	localparam int TIME_W     = 32;
	localparam int AVG_W      = 40;
	localparam int MAG_W      = SPEED_W + 1;
	localparam int PROD_W     = 15;

	// reset values
	localparam logic [MSD_W-1:0] MSD_RST = MSD_W'(100);
	localparam logic [THR_W-1:0] THR_RST = THR_W'(100);
	localparam logic [ADV_W-1:0] ADV_RST = ADV_W'(100);

	// advance target = ADV_BASE - (|speed| * ADV_SPAN) >> SPEED_SHIFT
	localparam int ADV_BASE    = 100;
	localparam int ADV_SPAN    = 60;
	localparam int SPEED_SHIFT = 7;

	// load compensation saturation
	localparam int COMP_MAX = 100;

	// configuration register indexes
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MAX_STEP_DELAY = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_LOAD_THRESHOLD = cfg_idx_t'(1);

	typedef logic [LOW_W-1:0] low_lvl_t;

endpackage

// ===== rtl/three_phase_trapezoid_commutator_core.sv =====
// Top level: trapezoidal three-phase commutator, one tick item per clock while results are taken.
`timescale 1ns / 1ps

// Each accepted item is one microsecond tick; every item yields exactly one
// result item carrying the high-side enables, the low-side PWM levels and a
// step flag. The block sustains one item per clock while results are taken:
// an item is held in the input register, then moves into the result register
// in the same edge that updates the commutation state, so its result is valid
// once it sits in the result register and the next item can enter every cycle.
// The two registers are the whole pipeline; the single state-update pass (IIR
// period average, load compensation, delay reload, trapezoid lookup) is
// combinational between them. While a result waits to be taken, the input
// register still takes one more item; in_ready then drops until the result is
// taken. Configuration (max_step_delay at index 0, load_threshold at index 1)
// is written through cfg_we/cfg_index/cfg_data and must only be changed while
// no item is in flight. Speed zero turns every drive output off; the first
// tick with a nonzero speed commutates at once.
module three_phase_trapezoid_commutator_core import tpc_pkg::*; #(
	parameter int PHASE_BITS = PHASE_BITS_DEF,
	parameter int IIR_SHIFT  = IIR_SHIFT_DEF,
	parameter int PWM_TOP    = PWM_TOP_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// tick items
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      speed_valid,
	input  logic signed [SPEED_W-1:0] speed_byte,
	input  logic                      sense_edge,
	// result items
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      high_a,
	output logic                      high_b,
	output logic                      high_c,
	output logic [LOW_W-1:0]          low_a,
	output logic [LOW_W-1:0]          low_b,
	output logic [LOW_W-1:0]          low_c,
	output logic                      step_taken,
	// configuration writes
	input  logic                      cfg_we,
	input  cfg_idx_t                  cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	localparam int SIXTH     = 1 << PHASE_BITS;
	localparam int FULL_TURN = 6 * SIXTH;
	localparam int IDX_W     = PHASE_BITS + 3;           // holds 0 .. FULL_TURN-1
	localparam int POS_W     = PHASE_BITS + 4;           // index plus up to 4 sixths
	localparam int LVL_W     = PHASE_BITS;
	localparam int CMP_W     = ((PHASE_BITS > LOW_W) ? PHASE_BITS : LOW_W) + 1;
	localparam int AQ_W      = AVG_W - IIR_SHIFT;

	// Trapezoid: ramp up over one sixth, flat for two, ramp down over one, off for two.
	function automatic logic [LVL_W-1:0] trap_shape(input logic [POS_W-1:0] pos_in);
		logic [POS_W-1:0] pos;
		pos = pos_in;
		if (pos >= POS_W'(FULL_TURN))
			pos = pos - POS_W'(FULL_TURN);
		if (pos < POS_W'(SIXTH))
			return LVL_W'(pos);
		else if (pos < POS_W'(3 * SIXTH))
			return LVL_W'(SIXTH - 1);
		else if (pos < POS_W'(4 * SIXTH))
			return LVL_W'(POS_W'(4 * SIXTH - 1) - pos);
		else
			return '0;
	endfunction

	// input register
	logic                    valid_s1;
	logic                    speed_valid_s1;
	logic [SPEED_W-1:0]      speed_byte_s1;
	logic                    sense_edge_s1;

	// configuration
	logic [MSD_W-1:0]        msd_q;
	logic [THR_W-1:0]        thr_q;

	// commutation state; high_q/low_q double as the result payload
	logic [IDX_W-1:0]        step_idx_q;
	logic [ADV_W-1:0]        adv_q;
	logic [COMP_W-1:0]       comp_q;
	logic [WAIT_W-1:0]       wait_q;
	logic [TIME_W-1:0]       since_q;    // ticks since the last sense edge (wraps)
	logic [AVG_W-1:0]        avg_q;
	logic [SPEED_W-1:0]      speed_q;
	logic [2:0]              high_q;
	low_lvl_t                low_q [3];
	logic                    step_q;
	logic                    out_valid_q;

	// combinational pass
	logic                    fire;
	logic [SPEED_W-1:0]      spd_new;
	logic                    neg;
	logic [MAG_W-1:0]        mag;
	logic [PROD_W-1:0]       prod;
	logic [ADV_W-1:0]        target;
	logic [ADV_W-1:0]        adv_next;
	logic [AVG_W-1:0]        avg_new;
	logic [AQ_W-1:0]         avg_scaled;
	logic [AQ_W-1:0]         avg_excess;
	logic [AQ_W-1:0]         comp_raw;
	logic [COMP_W-1:0]       comp_new;
	logic [WAIT_W-1:0]       delay_sum;
	logic [WAIT_W-1:0]       reload;
	logic [POS_W-1:0]        pos [3];
	logic [LVL_W-1:0]        lvl [3];
	logic [2:0]              step_hi;
	low_lvl_t                step_low [3];

	// item moves from the input register into the result register
	assign fire     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || fire;

	// speed command is taken before anything else in the tick
	assign spd_new = speed_valid_s1 ? speed_byte_s1 : speed_q;
	assign neg     = spd_new[SPEED_W-1];
	assign mag     = neg ? (MAG_W'(0) - {1'b1, spd_new}) : {1'b0, spd_new};
	assign prod    = PROD_W'(mag) * PROD_W'(ADV_SPAN);
	assign target  = ADV_W'(ADV_BASE) - ADV_W'(prod >> SPEED_SHIFT);

	always_comb begin
		if (adv_q < target)
			adv_next = adv_q + ADV_W'(1);
		else if (adv_q > target)
			adv_next = adv_q - ADV_W'(1);
		else
			adv_next = adv_q;
	end

	// IIR of the sense period: avg += period - avg >> IIR_SHIFT
	assign avg_new = sense_edge_s1
		? (avg_q + AVG_W'(since_q) - (avg_q >> IIR_SHIFT))
		: avg_q;

	// load compensation from the updated average
	assign avg_scaled = AQ_W'(avg_new >> IIR_SHIFT);
	assign avg_excess = avg_scaled - AQ_W'(thr_q);
	assign comp_raw   = avg_excess >> 2;

	always_comb begin
		if (avg_scaled <= AQ_W'(thr_q))
			comp_new = '0;
		else if (comp_raw > AQ_W'(COMP_MAX))
			comp_new = COMP_W'(COMP_MAX);
		else
			comp_new = COMP_W'(comp_raw);
	end

	// delay reload uses the compensation of the previous step
	assign delay_sum = WAIT_W'(adv_q) + WAIT_W'(comp_q);
	assign reload    = (delay_sum < msd_q) ? delay_sum : msd_q;

	// phase positions: B and C swap for reverse rotation
	assign pos[0] = POS_W'(step_idx_q);
	assign pos[1] = POS_W'(step_idx_q) + (neg ? POS_W'(4 * SIXTH) : POS_W'(2 * SIXTH));
	assign pos[2] = POS_W'(step_idx_q) + (neg ? POS_W'(2 * SIXTH) : POS_W'(4 * SIXTH));

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lvl[k]     = trap_shape(pos[k]);
			step_hi[k] = CMP_W'(lvl[k]) > CMP_W'(PWM_TOP);
			step_low[k] = step_hi[k] ? '0
				: LOW_W'(CMP_W'(PWM_TOP) - CMP_W'(lvl[k]));
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msd_q <= MSD_RST;
			thr_q <= THR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_STEP_DELAY: msd_q <= MSD_W'(cfg_data);
				CFG_LOAD_THRESHOLD: thr_q <= THR_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			speed_valid_s1 <= speed_valid;
			speed_byte_s1  <= speed_byte;
			sense_edge_s1  <= sense_edge;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// state update, one pass per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_idx_q <= '0;
			adv_q      <= ADV_RST;
			comp_q     <= '0;
			wait_q     <= '0;
			since_q    <= '0;
			avg_q      <= '0;
			speed_q    <= '0;
			high_q     <= '0;
			low_q      <= '{default: '0};
			step_q     <= 1'b0;
		end else if (fire) begin
			speed_q <= spd_new;
			avg_q   <= avg_new;
			since_q <= sense_edge_s1 ? TIME_W'(1) : since_q + TIME_W'(1);
			if (spd_new == '0) begin
				// stopped: drive off, next nonzero tick steps at once
				high_q <= '0;
				low_q  <= '{default: '0};
				wait_q <= '0;
				step_q <= 1'b0;
			end else if (wait_q > WAIT_W'(1)) begin
				wait_q <= wait_q - WAIT_W'(1);
				step_q <= 1'b0;
			end else begin
				high_q     <= step_hi;
				low_q      <= step_low;
				step_idx_q <= (step_idx_q == IDX_W'(FULL_TURN - 1))
					? '0 : step_idx_q + IDX_W'(1);
				wait_q     <= reload;
				adv_q      <= adv_next;
				comp_q     <= comp_new;
				step_q     <= 1'b1;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign high_a     = high_q[0];
	assign high_b     = high_q[1];
	assign high_c     = high_q[2];
	assign low_a      = low_q[0];
	assign low_b      = low_q[1];
	assign low_c      = low_q[2];
	assign step_taken = step_q;

endmodule

// ===== rtl/tpc_checker.sv =====
// Port-level checker for the commutator, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpc_checker import tpc_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      high_a,
	input logic                      high_b,
	input logic                      high_c,
	input logic [LOW_W-1:0]          low_a,
	input logic [LOW_W-1:0]          low_b,
	input logic [LOW_W-1:0]          low_c,
	input logic                      step_taken
);

	// a stalled result holds
	`ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(high_a) && $stable(high_b) && $stable(high_c) && $stable(low_a) && $stable(low_b) && $stable(low_c) && $stable(step_taken), "result changed while stalled")

	// input side only backs up when the result side is stalled
	`ASSERT_IMP(a_ready_stall, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

	// a phase never drives high side and low side together
	`ASSERT_IMP(a_no_shoot, out_valid, (!high_a || low_a == '0) && (!high_b || low_b == '0) && (!high_c || low_c == '0), "high and low side on in one phase")

endmodule

bind three_phase_trapezoid_commutator_core tpc_checker u_tpc_checker (.*);

// ===== dv/three_phase_trapezoid_commutator_core_tb.sv =====
// Self-checking testbench for the trapezoidal commutator core: predicted vs. observed drive items.
`timescale 1ns / 1ps

module three_phase_trapezoid_commutator_core_tb;
	import tpc_pkg::*;

	// one sixth of an electrical turn in step positions, and the whole turn
	localparam int SIXTH     = 1 << PHASE_BITS_DEF;
	localparam int TURN      = 6 * SIXTH;
	// generous cycle budget for the whole run
	localparam int LIMIT     = 100_000;
	// sense-free stretch so the next edge brings a long period that lifts the
	// averaged period above a zero threshold and turns load compensation on
	localparam int QUIET_RUN = 400;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one drive item as the block presents it
	typedef struct {
		logic     ha;
		logic     hb;
		logic     hc;
		low_lvl_t la;
		low_lvl_t lb;
		low_lvl_t lc;
		logic     stepped;
	} drive_t;

	// Commutation predictor plus the queue of drive items still owed by the block.
	class commutation_scoreboard;
		logic [MSD_W-1:0]   max_delay;
		logic [THR_W-1:0]   threshold;
		logic [8:0]         step_pos;
		logic [ADV_W-1:0]   advance;
		logic [COMP_W-1:0]  comp;
		logic [WAIT_W-1:0]  countdown;
		logic [TIME_W-1:0]  ticks;
		logic [TIME_W-1:0]  last_edge;
		logic [AVG_W-1:0]   period_acc;
		logic [SPEED_W-1:0] speed;
		logic [2:0]         high_on;
		low_lvl_t           low_lvl [3];
		drive_t             due_drives [$];
		int                 errors;
		int                 seen;

		function new();
			max_delay  = MSD_RST;
			threshold  = THR_RST;
			step_pos   = '0;
			advance    = ADV_RST;
			comp       = '0;
			countdown  = '0;
			ticks      = '0;
			last_edge  = '0;
			period_acc = '0;
			speed      = '0;
			high_on    = '0;
			foreach (low_lvl[k]) low_lvl[k] = '0;
			errors     = 0;
			seen       = 0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
			if (idx == CFG_MAX_STEP_DELAY) max_delay = val[MSD_W-1:0];
			else if (idx == CFG_LOAD_THRESHOLD) threshold = val[THR_W-1:0];
		endfunction

		function int outstanding();
			return due_drives.size();
		endfunction

		// rise over one sixth, flat top for two, fall over one, off for two
		function int unsigned trapezoid(int unsigned pos);
			if (pos >= TURN) pos -= TURN;
			if (pos < 3 * SIXTH) return (pos < SIXTH) ? pos : SIXTH - 1;
			if (pos < 4 * SIXTH) return 4 * SIXTH - 1 - pos;
			return 0;
		endfunction

		function void set_phase(int k, int unsigned level);
			if (level > PWM_TOP_DEF) begin
				high_on[k] = 1'b1;
				low_lvl[k] = '0;
			end else begin
				low_lvl[k] = low_lvl_t'(PWM_TOP_DEF - level);
			end
		endfunction

		function void commutate();
			logic             neg;
			int unsigned      mag;
			int unsigned      target;
			int unsigned      delay;
			logic [AVG_W-1:0] avg_ticks;
			logic [AVG_W-1:0] excess;
			neg    = speed[SPEED_W-1];
			mag    = neg ? 256 - speed : speed;
			target = ADV_BASE - ((mag * ADV_SPAN) >> SPEED_SHIFT);
			// reverse rotation swaps the B and C offsets
			high_on = '0;
			set_phase(0, trapezoid(step_pos));
			set_phase(1, trapezoid(step_pos + (neg ? 4 : 2) * SIXTH));
			set_phase(2, trapezoid(step_pos + (neg ? 2 : 4) * SIXTH));
			step_pos  = (step_pos == TURN - 1) ? '0 : step_pos + 1'b1;
			delay     = advance + comp;
			countdown = (delay < max_delay) ? WAIT_W'(delay) : max_delay;
			if (advance < target) advance++;
			else if (advance > target) advance--;
			avg_ticks = period_acc >> IIR_SHIFT_DEF;
			if (avg_ticks > threshold) begin
				excess = (avg_ticks - threshold) >> 2;
				comp   = (excess > COMP_MAX) ? COMP_W'(COMP_MAX) : excess[COMP_W-1:0];
			end else begin
				comp = '0;
			end
		endfunction

		// speed first, then sense edge, then the drive decision; clock advances last
		function void note_tick(logic take_speed, logic [SPEED_W-1:0] cmd, logic sense);
			logic [TIME_W-1:0] period;
			drive_t            res;
			if (take_speed) speed = cmd;
			if (sense) begin
				period     = ticks - last_edge;
				period_acc = period_acc + AVG_W'(period) - (period_acc >> IIR_SHIFT_DEF);
				last_edge  = ticks;
			end
			res.stepped = 1'b0;
			if (speed == '0) begin
				high_on   = '0;
				foreach (low_lvl[k]) low_lvl[k] = '0;
				countdown = '0;
			end else if (countdown > 1) begin
				countdown--;
			end else begin
				commutate();
				res.stepped = 1'b1;
			end
			res.ha = high_on[0];
			res.hb = high_on[1];
			res.hc = high_on[2];
			res.la = low_lvl[0];
			res.lb = low_lvl[1];
			res.lc = low_lvl[2];
			due_drives.push_back(res);
			ticks++;
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH %s", $time, msg);
			errors++;
		endtask

		task check_field(string name, logic [7:0] got, logic [7:0] want);
			if (got !== want)
				report($sformatf("item %0d %s: got %0d, want %0d", seen, name, got, want));
		endtask

		task check_drive(drive_t got);
			drive_t want;
			seen++;
			if (due_drives.size() == 0) begin
				report($sformatf("item %0d arrived with no tick pending", seen));
				return;
			end
			want = due_drives.pop_front();
			check_field("high_a",     got.ha,      want.ha);
			check_field("high_b",     got.hb,      want.hb);
			check_field("high_c",     got.hc,      want.hc);
			check_field("low_a",      got.la,      want.la);
			check_field("low_b",      got.lb,      want.lb);
			check_field("low_c",      got.lc,      want.lc);
			check_field("step_taken", got.stepped, want.stepped);
		endtask
	endclass

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      in_valid    = 1'b0;
	logic                      in_ready;
	logic                      speed_valid = 1'b0;
	logic signed [SPEED_W-1:0] speed_byte  = '0;
	logic                      sense_edge  = 1'b0;
	logic                      out_valid;
	logic                      out_ready   = 1'b0;
	logic                      high_a;
	logic                      high_b;
	logic                      high_c;
	low_lvl_t                  low_a;
	low_lvl_t                  low_b;
	low_lvl_t                  low_c;
	logic                      step_taken;
	logic                      cfg_we      = 1'b0;
	cfg_idx_t                  cfg_index   = CFG_MAX_STEP_DELAY;
	logic [CFG_DATA_W-1:0]     cfg_data    = '0;

	commutation_scoreboard board = new();

	// idling knobs: percent of cycles the sender holds off / receiver stalls;
	// calm forces a stretch with no idling on either side
	int   send_pct  = 0;
	int   stall_pct = 0;
	logic calm      = 1'b0;
	int   cycles    = 0;

	three_phase_trapezoid_commutator_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.speed_valid (speed_valid),
		.speed_byte  (speed_byte),
		.sense_edge  (sense_edge),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.high_a      (high_a),
		.high_b      (high_b),
		.high_c      (high_c),
		.low_a       (low_a),
		.low_b       (low_b),
		.low_c       (low_c),
		.step_taken  (step_taken),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("three_phase_trapezoid_commutator_core verification failed");
			$finish;
		end
	end

	// receiver backpressure
	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(99) >= stall_pct);
	end

	// Monitors sample at the edge, before any of this edge's updates land.
	// Every accepted tick owes exactly one drive item.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			board.note_tick(speed_valid, speed_byte, sense_edge);
	end

	always @(posedge clk) begin
		drive_t got;
		if (arst_n && out_valid && out_ready) begin
			got = '{ha: high_a, hb: high_b, hc: high_c, la: low_a, lb: low_b, lc: low_c,
				stepped: step_taken};
			board.check_drive(got);
		end
	end

	task automatic set_idle(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_pct = 0;  stall_pct = 0;  end
			IDLE_SEND: begin send_pct = 72; stall_pct = 0;  end
			IDLE_RECV: begin send_pct = 0;  stall_pct = 72; end
			default:   begin send_pct = 35; stall_pct = 35; end
		endcase
	endtask

	// Present one tick item and hold it until taken. Entered on the edge that
	// took the previous item, so valid stays high across back-to-back items.
	task automatic send_tick(input logic sv, input logic signed [SPEED_W-1:0] cmd,
		input logic sense);
		while (!calm && $urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		speed_valid <= sv;
		speed_byte  <= cmd;
		sense_edge  <= sense;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold off until every owed drive item is out, plus a margin
	// for the input and result registers.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Both registers in one burst; the enable stays high across the two writes.
	// Upper byte of the delay word is junk that the block must drop.
	task automatic configure(input logic [MSD_W-1:0] msd, input logic [THR_W-1:0] thr);
		logic [CFG_DATA_W-1:0] msd_word;
		msd_word  = {8'($urandom), msd};
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAX_STEP_DELAY;
		cfg_data  <= msd_word;
		@(posedge clk);
		cfg_index <= CFG_LOAD_THRESHOLD;
		cfg_data  <= thr;
		@(posedge clk);
		cfg_we    <= 1'b0;
		board.set_reg(CFG_MAX_STEP_DELAY, msd_word);
		board.set_reg(CFG_LOAD_THRESHOLD, thr);
	endtask

	// Mostly steady running with a held speed; now and then a new command,
	// biased toward stop and the extremes. Bytes without speed_valid are noise.
	task automatic random_tick(input int edge_div);
		logic                      sv;
		logic signed [SPEED_W-1:0] cmd;
		sv = ($urandom_range(19) == 0);
		case ($urandom_range(19))
			0, 1, 2: cmd = '0;
			3:       cmd = 8'sd127;
			4:       cmd = -8'sd128;
			5:       cmd = 8'sd1;
			6:       cmd = -8'sd1;
			default: cmd = SPEED_W'($urandom);
		endcase
		send_tick(sv, cmd, $urandom_range(edge_div - 1) == 0);
	endtask

	task automatic run_phase(input logic [MSD_W-1:0] msd, input logic [THR_W-1:0] thr,
		input idle_mode_t mode, input int edge_div, input int count, input int hold_at,
		input int quiet);
		drain();
		configure(msd, thr);
		set_idle(mode);
		// long sense-free run, then one edge carrying the whole gap as its period
		if (quiet > 0) begin
			calm = 1'b1;
			send_tick(1'b1, 8'sd127, 1'b0);
			for (int n = 0; n < quiet; n++)
				send_tick($urandom_range(499) == 0, SPEED_W'($urandom), 1'b0);
			send_tick(1'b0, SPEED_W'($urandom), 1'b1);
			calm = 1'b0;
		end
		for (int n = 0; n < count; n++) begin
			calm = (n % 64) < 10;
			if (hold_at != 0 && n == hold_at) drain();
			random_tick(edge_div);
		end
		calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed ticks at reset configuration: stop/start, direction flips,
		// speed extremes, ignored bytes and sense edges.
		set_idle(IDLE_NONE);
		send_tick(1'b0, 8'sd0,     1'b1);  // edge at tick zero, stopped
		send_tick(1'b1, 8'sd127,   1'b0);  // first nonzero speed steps at once
		send_tick(1'b0, -8'sd1,    1'b1);  // waiting; byte ignored
		send_tick(1'b1, -8'sd128,  1'b0);  // direction flip mid-wait
		send_tick(1'b1, 8'sd0,     1'b0);  // stop clears outputs and the wait
		send_tick(1'b1, -8'sd128,  1'b1);  // restart reversed, immediate step
		send_tick(1'b1, -8'sd1,    1'b0);
		send_tick(1'b1, 8'sd1,     1'b0);
		send_tick(1'b1, 8'sd0,     1'b0);
		send_tick(1'b1, 8'sd1,     1'b0);  // slowest forward, immediate step
		send_tick(1'b1, -8'sd1,    1'b1);
		send_tick(1'b1, 8'sd0,     1'b1);
		send_tick(1'b0, 8'sd127,   1'b0);  // stays stopped, byte ignored
		send_tick(1'b1, -8'sd1,    1'b0);
		send_tick(1'b1, 8'sd0,     1'b0);
		send_tick(1'b1, 8'sd127,   1'b1);
		send_tick(1'b1, 8'sd64,    1'b0);
		send_tick(1'b1, -8'sd64,   1'b1);
		send_tick(1'b0, -8'sd86,   1'b0);

		// smallest cap: a step on every tick while the speed is nonzero
		run_phase(8'd1, 16'd0, IDLE_NONE, 8, 150, 0, 0);
		// largest cap and threshold; one full drain partway through
		run_phase(8'd255, 16'hFFFF, IDLE_SEND, 200, 150, 125, 0);
		run_phase(8'd7, 16'd20, IDLE_RECV, 30, 150, 0, 0);
		run_phase(MSD_W'($urandom_range(1, 255)), THR_W'($urandom_range(0, 300)), IDLE_BOTH,
			$urandom_range(4, 60), 150, 0, 0);
		// zero threshold after a long period: compensation turns on
		run_phase(8'd255, 16'd0, IDLE_BOTH, 50, 100, 0, QUIET_RUN);

		drain();
		repeat (8) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0) begin
			$display("three_phase_trapezoid_commutator_core verification clean");
		end else begin
			$display("three_phase_trapezoid_commutator_core verification failed");
		end
		$finish;
	end

endmodule
